>>> rtl/core/recording_event_trigger_unit_macros.svh
// Assertion helpers for the trigger unit RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef RECORDING_EVENT_TRIGGER_UNIT_MACROS_SVH
`define RECORDING_EVENT_TRIGGER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define RETU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RETU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/retu_pkg.sv
`default_nettype none

package retu_pkg;

  // Field widths
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned AMPL_W  = 16;
  localparam int unsigned FREQ_W  = 18;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Trigger modes (code 3 is unused and never triggers on its own)
  localparam logic [MODE_W-1:0] MODE_LEVEL      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREQ       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREQ_LEVEL = 2'd2;

  // Request kinds
  localparam logic REQ_FRAME   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_FREQ_HZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPL_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_EVENT_FRAMES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_RECORD     = 3'd5;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0]  RST_TRIGGER_MODE     = MODE_LEVEL;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_THRESHOLD  = 16'd16384;
  localparam logic [FREQ_W-1:0]  RST_FILTER_FREQ_HZ   = 18'd15000;
  localparam logic [AMPL_W-1:0]  RST_AMPL_THRESHOLD   = 16'd0;
  localparam logic [CNT_W-1:0]   RST_MIN_EVENT_FRAMES = 8'd1;

  typedef enum logic [1:0] {
    ST_ARMED = 2'd0,
    ST_PRE   = 2'd1,
    ST_TRIG  = 2'd2
  } trig_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  trigger_mode;
    logic [LEVEL_W-1:0] level_threshold;
    logic [FREQ_W-1:0]  filter_freq_hz;
    logic [AMPL_W-1:0]  ampl_threshold;
    logic [CNT_W-1:0]   min_event_frames;
    logic               force_record;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic               peak_present;
    logic [LEVEL_W-1:0] peak_level;
    logic [AMPL_W-1:0]  max_ampl;
    logic [FREQ_W-1:0]  max_freq_hz;
  } item_t;

  typedef struct packed {
    logic               recording_trigger;
    logic [1:0]         trigger_state;
    logic [CNT_W-1:0]   frame_count;
    logic [LEVEL_W-1:0] held_peak;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/retu_cfg.sv
`default_nettype none

module retu_cfg
  import retu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_q;

  // Register file, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.trigger_mode     <= RST_TRIGGER_MODE;
      cfg_q.level_threshold  <= RST_LEVEL_THRESHOLD;
      cfg_q.filter_freq_hz   <= RST_FILTER_FREQ_HZ;
      cfg_q.ampl_threshold   <= RST_AMPL_THRESHOLD;
      cfg_q.min_event_frames <= RST_MIN_EVENT_FRAMES;
      cfg_q.force_record     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_MODE:     cfg_q.trigger_mode     <= cfg_data[MODE_W-1:0];
        REG_LEVEL_THRESHOLD:  cfg_q.level_threshold  <= cfg_data[LEVEL_W-1:0];
        REG_FILTER_FREQ_HZ:   cfg_q.filter_freq_hz   <= cfg_data[FREQ_W-1:0];
        REG_AMPL_THRESHOLD:   cfg_q.ampl_threshold   <= cfg_data[AMPL_W-1:0];
        REG_MIN_EVENT_FRAMES: cfg_q.min_event_frames <= cfg_data[CNT_W-1:0];
        REG_FORCE_RECORD:     cfg_q.force_record     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/retu_core.sv
`default_nettype none
`include "recording_event_trigger_unit_macros.svh"

module retu_core
  import retu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    res
);

  trig_state_t        trig_state, trig_state_next;
  logic [CNT_W-1:0]   frame_counter, frame_counter_next;
  logic               trigger_flag, trigger_flag_next;
  logic [LEVEL_W-1:0] peak_hold, peak_hold_next;

  logic [LEVEL_W-1:0] peak_eff;
  logic [CNT_W-1:0]   cnt_inc;
  logic               freq_ok;
  logic               level_ok;
  logic               mode_trig;
  logic               mode_pre;

  // Qualification of the current beat
  assign freq_ok  = (item.max_ampl > cfg.ampl_threshold) &&
                    (item.max_freq_hz >= cfg.filter_freq_hz);
  assign peak_eff = item.peak_present ? item.peak_level : peak_hold;
  assign level_ok = peak_eff >= cfg.level_threshold;
  assign cnt_inc  = (frame_counter == CNT_MAX) ? frame_counter : frame_counter + 1'b1;

  assign mode_trig = ((cfg.trigger_mode == MODE_LEVEL) && level_ok) || cfg.force_record;
  assign mode_pre  = ((cfg.trigger_mode == MODE_FREQ) && freq_ok) ||
                     ((cfg.trigger_mode == MODE_FREQ_LEVEL) && freq_ok && level_ok);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_state    <= ST_ARMED;
      frame_counter <= '0;
      trigger_flag  <= 1'b0;
      peak_hold     <= '0;
    end else begin
      trig_state    <= trig_state_next;
      frame_counter <= frame_counter_next;
      trigger_flag  <= trigger_flag_next;
      peak_hold     <= peak_hold_next;
    end
  end

  // Next state
  always_comb begin
    trig_state_next    = trig_state;
    frame_counter_next = frame_counter;
    trigger_flag_next  = trigger_flag;
    peak_hold_next     = peak_hold;
    if (fire) begin
      if (item.req_type == REQ_RELEASE) begin
        // release re-arms from any other state
        if (trig_state != ST_ARMED) begin
          trig_state_next    = ST_ARMED;
          frame_counter_next = '0;
          trigger_flag_next  = 1'b0;
          peak_hold_next     = peak_eff;
        end
      end else begin
        unique case (trig_state)
          ST_ARMED: begin
            peak_hold_next = peak_eff;
            if (mode_trig) begin
              trig_state_next   = ST_TRIG;
              trigger_flag_next = 1'b1;
            end else if (mode_pre) begin
              trig_state_next    = ST_PRE;
              frame_counter_next = '0;
            end
          end
          ST_PRE: begin
            if (freq_ok) begin
              frame_counter_next = cnt_inc;
              if (cnt_inc >= cfg.min_event_frames) begin
                trig_state_next   = ST_TRIG;
                trigger_flag_next = 1'b1;
              end
            end else begin
              trig_state_next = ST_ARMED;
            end
          end
          ST_TRIG: ;
          default: ;
        endcase
      end
    end
  end

  // Result shows the state after the update
  assign res.recording_trigger = trigger_flag_next;
  assign res.trigger_state     = trig_state_next;
  assign res.frame_count       = frame_counter_next;
  assign res.held_peak         = peak_hold_next;

  `RETU_ASSERT_ALWAYS(a_flag_matches_state, trigger_flag == (trig_state == ST_TRIG),
    "trigger flag out of step with trigger state")
  `RETU_ASSERT_NEXT(a_idle_holds_count, !fire, $stable(frame_counter) && $stable(peak_hold),
    "state changed without an accepted beat")
  `RETU_ASSERT_NEXT(a_pre_entry_clears, fire && trig_state == ST_ARMED && trig_state_next == ST_PRE,
    frame_counter == '0, "frame count not cleared on entering pre-trigger")
  `RETU_ASSERT_NEXT(a_trig_sticky,
    trig_state == ST_TRIG && !(fire && item.req_type == REQ_RELEASE),
    trig_state == ST_TRIG, "left triggered state without release")

endmodule

`default_nettype wire

>>> rtl/core/recording_event_trigger_unit.sv
// Recording event trigger unit.
// Slave stream (s_*): one beat per analysis frame or release request. tuser
// carries the request kind (0 frame check, 1 release); tdata carries the
// peak flag, peak level, dominant bin amplitude and its frequency.
// Master stream (m_*): exactly one result beat per accepted input beat,
// giving trigger flag, trigger state, frame count and held peak after the
// update, in input order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no beat is in flight.
// Path: an accepted beat passes the input register, then the result
// register, before its result shows on m_tdata.
// Throughput: one beat per cycle while m_tready is high; the state update
// is a single compare and increment step between the two registers.
// Reset (rst, synchronous): trigger state armed, counters and held peak
// cleared, registers at their reset values, both streams empty.
// Stall: with m_tready low the result register holds, the input register
// still takes one more beat, then s_tready drops until the result is taken.
`default_nettype none

module recording_event_trigger_unit
  import retu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [0] peak_present, [16:1] peak_level, [32:17] max_ampl, [50:33] max_freq_hz
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // [0] req_type
  input  wire logic                  s_tuser,
  // master stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] recording_trigger, [2:1] trigger_state, [10:3] frame_count,
  // [26:11] held_peak
  output logic [M_TDATA_W-1:0]       m_tdata,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_vld;
  result_t res;
  result_t out_res;
  logic    out_vld;
  logic    fire;

  retu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Beat moves from the input register into the result register
  assign fire     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type     <= s_tuser;
      in_item.peak_present <= s_tdata[0];
      in_item.peak_level   <= s_tdata[16:1];
      in_item.max_ampl     <= s_tdata[32:17];
      in_item.max_freq_hz  <= s_tdata[50:33];
    end
  end

  retu_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (in_item),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {5'd0, out_res.held_peak, out_res.frame_count,
                     out_res.trigger_state, out_res.recording_trigger};

endmodule

`default_nettype wire
